// ----- src/cbsg_pkg.sv -----
package cbsg_pkg;

  // Curve geometry
  localparam int STEP_COUNT = 100;
  localparam int PANEL_SPAN = 128;

  // Field widths
  localparam int CTRL_W = 7;
  localparam int STEP_W = 7;
  localparam int X_W    = 7;
  localparam int Y_W    = 8;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_X = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_Y = 2'd3;

  // Datapath widths
  localparam int PR_W   = 2 * STEP_W;  // s*r and s*s
  localparam int B12_W  = 19;          // 3*s*r^2 and 3*s^2*r, max 444411
  localparam int B3_W   = 27;          // 128*s^3, max 124198272
  localparam int TERM_W = CTRL_W + B12_W;
  localparam int NUM_W  = 27;          // numerator stays below 128 * N^3
  localparam int Q_W    = 8;

  // Divide by N^3 through a reciprocal multiply and one correction step
  localparam int DIVISOR     = STEP_COUNT * STEP_COUNT * STEP_COUNT;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DIVISOR;
  localparam int RECIP_W     = 11;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEP_COUNT - 1);
  localparam logic [Y_W-1:0]    Y_BASE   = Y_W'(PANEL_SPAN - 2);

  // Item latency from accept edge to the edge that takes the result
  localparam int LATENCY = 7;

  typedef struct packed {
    logic [B12_W-1:0] b1;
    logic [B12_W-1:0] b2;
    logic [B3_W-1:0]  b3;
  } basis_t;

endpackage

// ----- src/cbsg_basis.sv -----
// Bernstein basis weights for one step, two register stages.
module cbsg_basis (
  input  logic                        clk,
  input  logic [cbsg_pkg::STEP_W-1:0] step_i,
  output cbsg_pkg::basis_t            basis_o
);

  logic [cbsg_pkg::STEP_W-1:0] s_a_r;
  logic [cbsg_pkg::STEP_W-1:0] r_a_r;
  logic [cbsg_pkg::PR_W-1:0]   sr_a_r;
  logic [cbsg_pkg::PR_W-1:0]   ss_a_r;
  logic [cbsg_pkg::STEP_W-1:0] r_a_nxt;
  cbsg_pkg::basis_t            basis_r;
  cbsg_pkg::basis_t            basis_nxt;

  assign r_a_nxt = cbsg_pkg::STEP_W'(cbsg_pkg::STEP_COUNT) - step_i;

  // Stage A: first-order products
  always_ff @(posedge clk) begin
    s_a_r  <= step_i;
    r_a_r  <= r_a_nxt;
    sr_a_r <= cbsg_pkg::PR_W'(step_i) * cbsg_pkg::PR_W'(r_a_nxt);
    ss_a_r <= cbsg_pkg::PR_W'(step_i) * cbsg_pkg::PR_W'(step_i);
  end

  // Stage B: cubic weights
  always_comb begin
    basis_nxt.b1 = cbsg_pkg::B12_W'(3 * sr_a_r * r_a_r);
    basis_nxt.b2 = cbsg_pkg::B12_W'(3 * ss_a_r * r_a_r);
    basis_nxt.b3 = cbsg_pkg::B3_W'(cbsg_pkg::PANEL_SPAN * ss_a_r * s_a_r);
  end

  always_ff @(posedge clk) begin
    basis_r <= basis_nxt;
  end

  assign basis_o = basis_r;

endmodule

// ----- src/cbsg_coord.sv -----
// One curve coordinate: weight, sum, divide by N^3. Four register stages.
module cbsg_coord (
  input  logic                        clk,
  input  logic [cbsg_pkg::CTRL_W-1:0] ctrl1_i,
  input  logic [cbsg_pkg::CTRL_W-1:0] ctrl2_i,
  input  cbsg_pkg::basis_t            basis_i,
  output logic [cbsg_pkg::Q_W-1:0]    coord_o
);

  logic [cbsg_pkg::TERM_W-1:0] t1_c_r;
  logic [cbsg_pkg::TERM_W-1:0] t2_c_r;
  logic [cbsg_pkg::B3_W-1:0]   b3_c_r;
  logic [cbsg_pkg::NUM_W-1:0]  num_d_r;
  logic [cbsg_pkg::NUM_W-1:0]  num_e_r;
  logic [cbsg_pkg::PROD_W-1:0] prod_e_r;
  logic [cbsg_pkg::Q_W-1:0]    q_est;
  logic [cbsg_pkg::NUM_W-1:0]  rem;
  logic [cbsg_pkg::Q_W-1:0]    q_nxt;
  logic [cbsg_pkg::Q_W-1:0]    q_r;

  // Stage C: weight the control coordinates
  always_ff @(posedge clk) begin
    t1_c_r <= cbsg_pkg::TERM_W'(ctrl1_i) * cbsg_pkg::TERM_W'(basis_i.b1);
    t2_c_r <= cbsg_pkg::TERM_W'(ctrl2_i) * cbsg_pkg::TERM_W'(basis_i.b2);
    b3_c_r <= basis_i.b3;
  end

  // Stage D: numerator
  always_ff @(posedge clk) begin
    num_d_r <= cbsg_pkg::NUM_W'(t1_c_r) + cbsg_pkg::NUM_W'(t2_c_r)
             + cbsg_pkg::NUM_W'(b3_c_r);
  end

  // Stage E: reciprocal multiply, estimate is exact or one low
  always_ff @(posedge clk) begin
    num_e_r  <= num_d_r;
    prod_e_r <= cbsg_pkg::PROD_W'(num_d_r)
              * cbsg_pkg::PROD_W'(cbsg_pkg::RECIP);
  end

  // Stage F: correct the estimate
  always_comb begin
    q_est = cbsg_pkg::Q_W'(prod_e_r >> cbsg_pkg::RECIP_SHIFT);
    rem   = num_e_r - cbsg_pkg::NUM_W'(cbsg_pkg::NUM_W'(q_est)
                                       * cbsg_pkg::NUM_W'(cbsg_pkg::DIVISOR));
    if (rem >= cbsg_pkg::NUM_W'(cbsg_pkg::DIVISOR)) begin
      q_nxt = q_est + cbsg_pkg::Q_W'(1);
    end else begin
      q_nxt = q_est;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign coord_o = q_r;

endmodule

// ----- src/cubic_bezier_segment_generator_core.sv -----
// Channel   Ports                                   Handshake
// input     start, busy, in_step_index              taken when start && !busy
// result    out_valid, out_from_x/y, out_to_x/y     one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_wdata            written when cfg_we
//
// One item enters every cycle; busy is always low. A result passes through
// the seven register stages: input clamp,
// two basis stages, weighting multiply, sum, reciprocal multiply, correction.
// Reset clears the control registers and the valid bits in flight; payload
// registers are not reset. The receiver cannot stall, so nothing is held.
module cubic_bezier_segment_generator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [cbsg_pkg::STEP_W-1:0]    in_step_index,
  input  logic                           cfg_we,
  input  logic [cbsg_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [cbsg_pkg::CTRL_W-1:0]    cfg_wdata,
  output logic                           out_valid,
  output logic [cbsg_pkg::X_W-1:0]       out_from_x,
  output logic signed [cbsg_pkg::Y_W-1:0] out_from_y,
  output logic [cbsg_pkg::X_W-1:0]       out_to_x,
  output logic signed [cbsg_pkg::Y_W-1:0] out_to_y
);

  logic                        accept;
  logic [cbsg_pkg::LATENCY-1:0] valid_r;
  logic [cbsg_pkg::LATENCY-1:0] valid_nxt;

  logic [cbsg_pkg::CTRL_W-1:0] ctrl1_x_r, ctrl1_y_r, ctrl2_x_r, ctrl2_y_r;
  logic [cbsg_pkg::CTRL_W-1:0] ctrl1_x_nxt, ctrl1_y_nxt, ctrl2_x_nxt, ctrl2_y_nxt;

  logic [cbsg_pkg::STEP_W-1:0] step_clamp;
  logic [cbsg_pkg::STEP_W-1:0] step_from_r;
  logic [cbsg_pkg::STEP_W-1:0] step_to_r;

  cbsg_pkg::basis_t            basis_from;
  cbsg_pkg::basis_t            basis_to;
  logic [cbsg_pkg::Q_W-1:0]    from_vx, from_vy, to_vx, to_vy;

  // No back-pressure anywhere: take an item every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Config registers; the two-bit index selects one of four registers.
  always_comb begin
    ctrl1_x_nxt = ctrl1_x_r;
    ctrl1_y_nxt = ctrl1_y_r;
    ctrl2_x_nxt = ctrl2_x_r;
    ctrl2_y_nxt = ctrl2_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cbsg_pkg::REG_CTRL1_X: ctrl1_x_nxt = cfg_wdata;
        cbsg_pkg::REG_CTRL1_Y: ctrl1_y_nxt = cfg_wdata;
        cbsg_pkg::REG_CTRL2_X: ctrl2_x_nxt = cfg_wdata;
        cbsg_pkg::REG_CTRL2_Y: ctrl2_y_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_x_r <= '0;
      ctrl1_y_r <= '0;
      ctrl2_x_r <= '0;
      ctrl2_y_r <= '0;
    end else begin
      ctrl1_x_r <= ctrl1_x_nxt;
      ctrl1_y_r <= ctrl1_y_nxt;
      ctrl2_x_r <= ctrl2_x_nxt;
      ctrl2_y_r <= ctrl2_y_nxt;
    end
  end

  // Valid bits travel alongside the datapath stages.
  assign valid_nxt = {valid_r[cbsg_pkg::LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Clamp the step into 1..N-1; a step of zero acts as the first segment.
  always_comb begin
    if (in_step_index < cbsg_pkg::STEP_MIN) begin
      step_clamp = cbsg_pkg::STEP_MIN;
    end else if (in_step_index > cbsg_pkg::STEP_MAX) begin
      step_clamp = cbsg_pkg::STEP_MAX;
    end else begin
      step_clamp = in_step_index;
    end
  end

  // Input stage: hold both ends of the segment.
  always_ff @(posedge clk) begin
    step_from_r <= step_clamp - cbsg_pkg::STEP_W'(1);
    step_to_r   <= step_clamp;
  end

  // Basis weights, shared by both axes of each end point.
  cbsg_basis u_basis_from (
    .clk     (clk),
    .step_i  (step_from_r),
    .basis_o (basis_from)
  );

  cbsg_basis u_basis_to (
    .clk     (clk),
    .step_i  (step_to_r),
    .basis_o (basis_to)
  );

  // Four coordinate lanes: start x/y and end x/y.
  cbsg_coord u_coord_from_x (
    .clk     (clk),
    .ctrl1_i (ctrl1_x_r),
    .ctrl2_i (ctrl2_x_r),
    .basis_i (basis_from),
    .coord_o (from_vx)
  );

  cbsg_coord u_coord_from_y (
    .clk     (clk),
    .ctrl1_i (ctrl1_y_r),
    .ctrl2_i (ctrl2_y_r),
    .basis_i (basis_from),
    .coord_o (from_vy)
  );

  cbsg_coord u_coord_to_x (
    .clk     (clk),
    .ctrl1_i (ctrl1_x_r),
    .ctrl2_i (ctrl2_x_r),
    .basis_i (basis_to),
    .coord_o (to_vx)
  );

  cbsg_coord u_coord_to_y (
    .clk     (clk),
    .ctrl1_i (ctrl1_y_r),
    .ctrl2_i (ctrl2_y_r),
    .basis_i (basis_to),
    .coord_o (to_vy)
  );

  // Panel mapping: x as is, y flipped against the bottom row.
  assign out_valid  = valid_r[cbsg_pkg::LATENCY-1];
  assign out_from_x = from_vx[cbsg_pkg::X_W-1:0];
  assign out_to_x   = to_vx[cbsg_pkg::X_W-1:0];
  assign out_from_y = cbsg_pkg::Y_BASE - cbsg_pkg::Y_W'(from_vy);
  assign out_to_y   = cbsg_pkg::Y_BASE - cbsg_pkg::Y_W'(to_vy);

endmodule

// ----- src/cbsg_checker.sv -----
module cbsg_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [cbsg_pkg::STEP_W-1:0]    in_step_index,
  input logic                           out_valid,
  input logic [cbsg_pkg::X_W-1:0]       out_from_x,
  input logic signed [cbsg_pkg::Y_W-1:0] out_from_y,
  input logic signed [cbsg_pkg::Y_W-1:0] out_to_y
);

  logic accept;
  assign accept = start && !busy;

  // Every taken item gives exactly one result, a fixed latency later.
  a_item_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(cbsg_pkg::LATENCY) out_valid)
    else $error("item taken without a result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, cbsg_pkg::LATENCY))
    else $error("result without a taken item");

  // The first segment starts at the curve origin.
  a_first_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(accept && (in_step_index <= cbsg_pkg::STEP_MIN),
                       cbsg_pkg::LATENCY)
    |-> (out_from_x == '0) && (out_from_y == cbsg_pkg::Y_BASE))
    else $error("first segment does not start at origin");

  // y never falls below row -1, the lowest of the panel rows -1..126.
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_from_y >= -8'sd1) && (out_to_y >= -8'sd1))
    else $error("y out of range");

endmodule

bind cubic_bezier_segment_generator_core cbsg_checker u_cbsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_step_index (in_step_index),
  .out_valid     (out_valid),
  .out_from_x    (out_from_x),
  .out_from_y    (out_from_y),
  .out_to_y      (out_to_y)
);
